>>> hw/rtl/tsat_pkg.sv
`timescale 1ns / 1ps
package tsat_pkg;

  localparam int KEY_W   = 16;
  localparam int HEAP_W  = 8;
  localparam int SIZE_W  = 31;
  localparam int TOTAL_W = 48;
  localparam int COUNT_W = 32;
  localparam int SLOT_W  = 10;
  localparam int ECNT_W  = 11;

  localparam logic [TOTAL_W-1:0] SAT_TOTAL = '1;
  localparam logic [COUNT_W-1:0] SAT_COUNT = '1;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic REG_SIZE_MATTERS = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [HEAP_W-1:0]  heap;
    logic [TOTAL_W-1:0] req_total;
    logic [TOTAL_W-1:0] act_total;
    logic [SIZE_W-1:0]  max_req;
    logic [COUNT_W-1:0] alloc_count;
  } entry_t;

endpackage

>>> hw/rtl/tsat_store.sv
`timescale 1ns / 1ps
module tsat_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  tsat_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output tsat_pkg::entry_t rdata_o
);
  import tsat_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tagged_stat_accumulate_table_core.sv
`timescale 1ns / 1ps
// Allocation statistics table with one request in flight at a time. An update
// walks the valid entries one per cycle through the single read port of the
// entry memory. A hit then uses the shared 48-bit saturating adder (requested
// total unless size_matters is set, then actual total), writes back and gives
// the result; an insert writes back, a full table flags overflow. A read
// issues the memory read, then captures and gives the entry; a bad index, a
// clear or an unused function code goes straight to the result. Each result
// waits for the previous one to be accepted. The entry memory is never
// cleared; only entries below the entry count are read. The user must write
// size_matters via the APB port, addresses 0-3, while idle; not enforced.
module tagged_stat_accumulate_table_core #(
  parameter int ENTRIES  = 1024,
  parameter int KEY_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [tsat_pkg::KEY_W-1:0]    type_key_i,
  input  logic [tsat_pkg::HEAP_W-1:0]   heap_i,
  input  logic [tsat_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [tsat_pkg::SIZE_W-1:0]   act_size_i,
  input  logic [tsat_pkg::SLOT_W-1:0]   index_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic                          inserted_o,
  output logic                          overflow_o,
  output logic                          bad_index_o,
  output logic [tsat_pkg::SLOT_W-1:0]   slot_o,
  output logic [tsat_pkg::KEY_W-1:0]    out_key_o,
  output logic [tsat_pkg::HEAP_W-1:0]   out_heap_o,
  output logic [tsat_pkg::TOTAL_W-1:0]  out_req_total_o,
  output logic [tsat_pkg::TOTAL_W-1:0]  out_act_total_o,
  output logic [tsat_pkg::SIZE_W-1:0]   out_max_req_o,
  output logic [tsat_pkg::COUNT_W-1:0]  out_alloc_count_o,
  output logic [tsat_pkg::ECNT_W-1:0]   entry_count_o
);
  import tsat_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? '1 : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_ADD_A  = 3'd2;
  localparam logic [2:0] ST_ADD_B  = 3'd3;
  localparam logic [2:0] ST_WB     = 3'd4;
  localparam logic [2:0] ST_RD_ISS = 3'd5;
  localparam logic [2:0] ST_RD_DAT = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  typedef struct packed {
    logic hit;
    logic inserted;
    logic overflow;
    logic bad_index;
  } flags_t;

  logic [2:0]          state_q, state_d;
  logic                size_matters_q;
  logic [CW-1:0]       used_q, used_d;
  logic [CW-1:0]       iss_q, iss_d;
  logic [AW-1:0]       cmp_q, cmp_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]       wr_addr_q, wr_addr_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  entry_t              ent_q, ent_d;
  flags_t              flags_q, flags_d;

  logic [KEY_W-1:0]    key_q;
  logic [HEAP_W-1:0]   heap_q;
  logic [SIZE_W-1:0]   req_q;
  logic [SIZE_W-1:0]   act_q;
  logic [SLOT_W-1:0]   idx_q;

  logic                out_valid_q, out_valid_d;
  flags_t              out_flags_q;
  logic [SLOT_W-1:0]   out_slot_q;
  entry_t              out_ent_q;
  logic [ECNT_W-1:0]   out_ecnt_q;

  logic                in_acc;
  logic                cfg_wr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  entry_t              rd_data;
  logic                mem_we;
  logic                out_load;
  logic                match;
  logic [TOTAL_W-1:0]  add_a;
  logic [SIZE_W-1:0]   add_b;
  logic [TOTAL_W:0]    add_sum;
  logic [TOTAL_W-1:0]  add_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SIZE_MATTERS) ? {31'd0, size_matters_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_matters_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == REG_SIZE_MATTERS) begin
      size_matters_q <= pwdata[0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  tsat_store #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr_q),
    .wdata_i (ent_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign add_a   = (state_q == ST_ADD_A) ? ent_q.req_total : ent_q.act_total;
  assign add_b   = (state_q == ST_ADD_A) ? req_q : act_q;
  assign add_sum = {1'b0, add_a} + {{(TOTAL_W + 1 - SIZE_W){1'b0}}, add_b};
  assign add_res = add_sum[TOTAL_W] ? SAT_TOTAL : add_sum[TOTAL_W-1:0];

  assign match = (state_q == ST_SCAN) && cmp_vld_q &&
                 rd_data.heap == heap_q && rd_data.key == key_q &&
                 (!size_matters_q ||
                  rd_data.req_total == {{(TOTAL_W - SIZE_W){1'b0}}, req_q});

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    iss_d       = iss_q;
    cmp_d       = cmp_q;
    cmp_vld_d   = cmp_vld_q;
    wr_addr_d   = wr_addr_q;
    slot_d      = slot_q;
    ent_d       = ent_q;
    flags_d     = flags_q;
    rd_en       = 1'b0;
    rd_addr     = iss_q[AW-1:0];
    mem_we      = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          flags_d = '0;
          ent_d   = '0;
          slot_d  = '0;
          case (func_i)
            FUNC_UPDATE: begin
              iss_d     = '0;
              cmp_vld_d = 1'b0;
              state_d   = ST_SCAN;
            end
            FUNC_CLEAR: begin
              used_d  = '0;
              state_d = ST_FIN;
            end
            FUNC_READ: begin
              if (IW'(index_i) < IW'(used_q)) begin
                state_d = ST_RD_ISS;
              end else begin
                flags_d.bad_index = 1'b1;
                slot_d            = index_i;
                state_d           = ST_FIN;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          ent_d         = rd_data;
          slot_d        = SLOT_W'(cmp_q);
          wr_addr_d     = cmp_q;
          flags_d.hit   = 1'b1;
          state_d       = ST_ADD_A;
        end else if (iss_q < used_q) begin
          rd_en     = 1'b1;
          iss_d     = iss_q + CW'(1);
          cmp_d     = iss_q[AW-1:0];
          cmp_vld_d = 1'b1;
        end else if (used_q < CW'(ENTRIES)) begin
          ent_d.key         = key_q;
          ent_d.heap        = heap_q;
          ent_d.req_total   = {{(TOTAL_W - SIZE_W){1'b0}}, req_q};
          ent_d.act_total   = {{(TOTAL_W - SIZE_W){1'b0}}, act_q};
          ent_d.max_req     = req_q;
          ent_d.alloc_count = COUNT_W'(1);
          wr_addr_d         = used_q[AW-1:0];
          slot_d            = SLOT_W'(used_q);
          used_d            = used_q + CW'(1);
          flags_d.inserted  = 1'b1;
          state_d           = ST_WB;
        end else begin
          flags_d.overflow = 1'b1;
          state_d          = ST_FIN;
        end
      end
      ST_ADD_A: begin
        if (!size_matters_q) begin
          ent_d.req_total = add_res;
        end
        if (req_q >= ent_q.max_req) begin
          ent_d.max_req = req_q;
        end
        if (ent_q.alloc_count != SAT_COUNT) begin
          ent_d.alloc_count = ent_q.alloc_count + COUNT_W'(1);
        end
        state_d = ST_ADD_B;
      end
      ST_ADD_B: begin
        ent_d.act_total = add_res;
        state_d         = ST_WB;
      end
      ST_WB: begin
        mem_we  = 1'b1;
        state_d = ST_FIN;
      end
      ST_RD_ISS: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_q);
        state_d = ST_RD_DAT;
      end
      ST_RD_DAT: begin
        ent_d   = rd_data;
        slot_d  = idx_q;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q     <= cmp_d;
    wr_addr_q <= wr_addr_d;
    slot_q    <= slot_d;
    ent_q     <= ent_d;
    flags_q   <= flags_d;
    if (in_acc) begin
      key_q  <= type_key_i & KEY_MASK;
      heap_q <= heap_i;
      req_q  <= req_size_i;
      act_q  <= act_size_i;
      idx_q  <= index_i;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_flags_q <= flags_q;
      out_slot_q  <= slot_q;
      out_ent_q   <= ent_q;
      out_ecnt_q  <= ECNT_W'(used_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = out_flags_q.hit;
  assign inserted_o        = out_flags_q.inserted;
  assign overflow_o        = out_flags_q.overflow;
  assign bad_index_o       = out_flags_q.bad_index;
  assign slot_o            = out_slot_q;
  assign out_key_o         = out_ent_q.key;
  assign out_heap_o        = out_ent_q.heap;
  assign out_req_total_o   = out_ent_q.req_total;
  assign out_act_total_o   = out_ent_q.act_total;
  assign out_max_req_o     = out_ent_q.max_req;
  assign out_alloc_count_o = out_ent_q.alloc_count;
  assign entry_count_o     = out_ecnt_q;

`ifndef ASSERT_OFF
  a_used_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_wb_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> CW'(wr_addr_q) < used_q)
    else $error("write-back outside valid entries");

  a_one_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({out_flags_q.hit, out_flags_q.inserted,
                              out_flags_q.overflow, out_flags_q.bad_index}))
    else $error("more than one result flag set");

  a_leave_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("request accepted without leaving idle");

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_flags_q.hit || out_flags_q.inserted)) |->
      out_ent_q.alloc_count != '0)
    else $error("touched entry with zero allocation count");
`endif

endmodule
